/* hw/rtl/tci_pkg.sv */
`timescale 1ns / 1ps
package tci_pkg;

    localparam int MAX_POINTS = 256;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [0:0] REG_REF_PRESSURE = 1'b0;
    localparam logic [0:0] REG_NOZZLE_AREA = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_WR,
        S_Q_LAST,
        S_Q_SRCH,
        S_Q_RD1,
        S_Q_RD2,
        S_Q_MUL,
        S_Q_DIV,
        S_Q_SUM,
        S_OUT
    } t_state;

endpackage

/* hw/rtl/thrust_curve_interpolator_top.sv */
`timescale 1ns / 1ps
// Piecewise-linear thrust curve table. Beats on the slave side carry a command: clear the
// table, append a (time, thrust) point, or query the thrust at a time; every beat gives
// exactly one result beat. A clear, a dropped point or an unused command goes from acceptance
// straight to the output state. An append reads the last stored time and then writes the
// point, or, when the first point has nonzero time, first stores a zero-time point with its
// own read and write. A query runs a binary search over the count-1 candidate points, at
// most 8 steps for a full table; each step reads the single time memory and compares the
// registered result in its second half. The slope division runs one quotient bit per cycle
// over 64 bits. One item is handled at a time; the result is held in an output register
// until taken, and the next beat is accepted once that register is free. Table memories
// need no clearing after reset.
module thrust_curve_interpolator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], point_time[33:2], point_thrust[65:34], query_time[97:66],
    // ambient_pressure[121:98], zero pad to 128
    input  logic [127:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // thrust_out[31:0], status[33:32], zero pad to 40
    output logic [39:0] m_axis_tdata
);

    localparam int IW = tci_pkg::IDX_W;
    localparam int CW = tci_pkg::CNT_W;

    function automatic logic [32:0] r_d_next_mag(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        d = 33'(signed'(a)) - 33'(signed'(b));
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    // Configuration registers.
    logic [23:0] r_ref_p, r_area;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_p <= 24'd101325;
            r_area <= 24'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tci_pkg::REG_REF_PRESSURE: r_ref_p <= i_cfg_data;
                tci_pkg::REG_NOZZLE_AREA: r_area <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Table memories: one synchronous read port and one write port each.
    logic [31:0] mem_t [tci_pkg::MAX_POINTS];
    logic [31:0] mem_f [tci_pkg::MAX_POINTS];
    logic          mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    logic [31:0]   mem_wt, mem_wf, r_rd_t, r_rd_f;
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_t[mem_wa] <= mem_wt;
            mem_f[mem_wa] <= mem_wf;
        end
        r_rd_t <= mem_t[mem_ra];
        r_rd_f <= mem_f[mem_ra];
    end

    tci_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic          r_loaded;
    logic [31:0]   r_pt, r_pf, r_q;
    logic [23:0]   r_amb;
    logic          r_zero_first;
    logic [CW-1:0] r_lo, r_hi;
    logic [31:0]   r_t1, r_f1;
    logic signed [32:0] r_d;
    logic [63:0]   r_num;
    logic [31:0]   r_dt;
    logic [63:0]   r_quo;
    logic [32:0]   r_rem;
    logic [6:0]    r_bit;
    logic          r_interp;
    logic signed [48:0] r_corr;
    logic          r_ovalid;
    logic [31:0]   r_othrust;
    logic [1:0]    r_ostat;

    wire [CW-1:0] mid = r_lo + ((r_hi - r_lo) >> 1);
    wire [CW-1:0] cnt_m1 = r_count - CW'(1);
    wire          accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == tci_pkg::S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {6'd0, r_ostat, r_othrust};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tci_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_axis_tdata[1:0] == tci_pkg::CMD_APPEND) begin
                        n_state = (r_count >= CW'(tci_pkg::MAX_POINTS))
                            ? tci_pkg::S_OUT : tci_pkg::S_APP_RD;
                    end else if (s_axis_tdata[1:0] == tci_pkg::CMD_QUERY) begin
                        n_state = (!r_loaded || r_count < CW'(2))
                            ? tci_pkg::S_OUT : tci_pkg::S_Q_LAST;
                    end else begin
                        n_state = tci_pkg::S_OUT;
                    end
                end
            end
            tci_pkg::S_APP_RD: n_state = tci_pkg::S_APP_WR;
            // After the zero-time point, the last stored time is read again before the
            // point itself is written.
            tci_pkg::S_APP_WR: n_state = r_zero_first ? tci_pkg::S_APP_RD : tci_pkg::S_OUT;
            tci_pkg::S_Q_LAST: n_state = (r_q > r_rd_t) ? tci_pkg::S_OUT : tci_pkg::S_Q_SRCH;
            tci_pkg::S_Q_SRCH: n_state = (r_lo < r_hi) ? tci_pkg::S_Q_SRCH : tci_pkg::S_Q_RD1;
            tci_pkg::S_Q_RD1: n_state = tci_pkg::S_Q_RD2;
            tci_pkg::S_Q_RD2: n_state = tci_pkg::S_Q_MUL;
            tci_pkg::S_Q_MUL: n_state = tci_pkg::S_Q_DIV;
            tci_pkg::S_Q_DIV: n_state = (r_bit == 7'd0) ? tci_pkg::S_Q_SUM : tci_pkg::S_Q_DIV;
            tci_pkg::S_Q_SUM: n_state = tci_pkg::S_OUT;
            tci_pkg::S_OUT: n_state = tci_pkg::S_IDLE;
            default: n_state = tci_pkg::S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_count[IW-1:0];
        mem_wt = r_pt;
        mem_wf = r_pf;
        mem_ra = cnt_m1[IW-1:0];
        unique case (r_state)
            tci_pkg::S_APP_WR: begin
                mem_we = 1'b1;
                if (r_zero_first) begin
                    mem_wt = 32'd0;
                    mem_wf = 32'd0;
                end else if (r_count != CW'(0) && r_pt < r_rd_t) begin
                    // Out-of-order time is raised to the last stored time.
                    mem_wt = r_rd_t;
                end
            end
            tci_pkg::S_Q_SRCH: begin
                mem_ra = mid[IW-1:0];
                if (r_lo >= r_hi) begin
                    mem_ra = IW'(r_lo - CW'(1));
                end
            end
            // The upper bracket point is read here and held through the multiply cycle.
            tci_pkg::S_Q_RD1, tci_pkg::S_Q_RD2: mem_ra = r_lo[IW-1:0];
            default: ;
        endcase
    end

    // The search issues a read of mid, then consumes the registered result in the next cycle;
    // a flag marks which half of the step is running.
    logic r_phase;
    logic [63:0] sh_rem;
    logic [32:0] trial;
    logic signed [33:0] sum_base;
    logic signed [49:0] total;
    always_comb begin
        sh_rem = 64'({r_rem[31:0], r_num[63]});
        trial = 33'(sh_rem[32:0]);
        sum_base = 34'(signed'(r_f1));
        if (r_interp) begin
            sum_base = r_d[32] ? 34'(signed'(r_f1)) - 34'(signed'({1'b0, r_quo[32:0]}))
                               : 34'(signed'(r_f1)) + 34'(signed'({1'b0, r_quo[32:0]}));
        end
        total = 50'(sum_base) + 50'(r_corr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tci_pkg::S_IDLE;
            r_count <= '0;
            r_loaded <= 1'b0;
            r_ovalid <= 1'b0;
            r_zero_first <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                tci_pkg::S_IDLE: begin
                    if (accept) begin
                        r_pt <= s_axis_tdata[33:2];
                        r_pf <= s_axis_tdata[65:34];
                        r_q <= s_axis_tdata[97:66];
                        r_amb <= s_axis_tdata[121:98];
                        r_othrust <= 32'd0;
                        r_ostat <= tci_pkg::ST_OK;
                        r_zero_first <= (r_count == CW'(0)) && (s_axis_tdata[33:2] != 32'd0);
                        if (s_axis_tdata[1:0] == tci_pkg::CMD_CLEAR) begin
                            r_count <= '0;
                            r_loaded <= 1'b0;
                        end else if (s_axis_tdata[1:0] == tci_pkg::CMD_APPEND) begin
                            if (r_count >= CW'(tci_pkg::MAX_POINTS))
                                r_ostat <= tci_pkg::ST_FULL;
                        end else if (s_axis_tdata[1:0] == tci_pkg::CMD_QUERY) begin
                            if (!r_loaded || r_count < CW'(2))
                                r_ostat <= tci_pkg::ST_RANGE;
                        end
                    end
                end
                tci_pkg::S_APP_WR: begin
                    if (r_count < CW'(tci_pkg::MAX_POINTS)) r_count <= r_count + CW'(1);
                    r_zero_first <= 1'b0;
                    r_loaded <= 1'b1;
                end
                tci_pkg::S_Q_LAST: begin
                    if (r_q > r_rd_t) r_ostat <= tci_pkg::ST_RANGE;
                    r_lo <= CW'(1);
                    r_hi <= cnt_m1;
                    r_phase <= 1'b0;
                end
                tci_pkg::S_Q_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_phase <= !r_phase;
                        if (r_phase) begin
                            if (r_rd_t < r_q) r_lo <= mid + CW'(1);
                            else r_hi <= mid;
                        end
                    end
                end
                tci_pkg::S_Q_RD1: begin
                    r_t1 <= r_rd_t;
                    r_f1 <= r_rd_f;
                end
                tci_pkg::S_Q_RD2: ;
                tci_pkg::S_Q_MUL: begin
                    r_d <= 33'(signed'(r_rd_f)) - 33'(signed'(r_f1));
                    r_interp <= (r_rd_t > r_t1) && (r_q > r_t1);
                    r_dt <= r_rd_t - r_t1;
                    // |d| * min(q - t1, dt), 33 x 32 bits.
                    begin
                        logic [32:0] mag;
                        logic [31:0] dq;
                        mag = r_d_next_mag(r_rd_f, r_f1);
                        dq = ((r_q - r_t1) > (r_rd_t - r_t1)) ? (r_rd_t - r_t1) : (r_q - r_t1);
                        r_num <= 64'(mag) * 64'(dq);
                    end
                    r_quo <= '0;
                    r_rem <= '0;
                    r_bit <= 7'd63;
                    begin
                        logic signed [24:0] dp;
                        logic [23:0] pm;
                        logic [47:0] prod;
                        dp = 25'(signed'({1'b0, r_ref_p})) - 25'(signed'({1'b0, r_amb}));
                        pm = dp[24] ? 24'(-dp) : dp[23:0];
                        prod = 48'(pm) * 48'(r_area);
                        r_corr <= dp[24] ? -49'(signed'({9'd0, prod[47:8]}))
                                         : 49'(signed'({9'd0, prod[47:8]}));
                    end
                end
                tci_pkg::S_Q_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    r_num <= {r_num[62:0], 1'b0};
                    if (trial >= {1'b0, r_dt}) begin
                        r_rem <= trial - {1'b0, r_dt};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_bit <= r_bit - 7'd1;
                end
                tci_pkg::S_Q_SUM: begin
                    if (total > 50'sd2147483647) r_othrust <= 32'h7fffffff;
                    else if (total < -50'sd2147483648) r_othrust <= 32'h80000000;
                    else r_othrust <= total[31:0];
                end
                tci_pkg::S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule

/* tb/sv/thrust_curve_interpolator_top_test.sv */
`timescale 1ns / 1ps
module thrust_curve_interpolator_top_test;

    // One command beat as the testbench sees it.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] point_time;
        logic [31:0] point_thrust;
        logic [31:0] query_time;
        logic [23:0] ambient_pressure;
    } t_curve_cmd;

    // One result beat.
    typedef struct packed {
        logic [31:0] thrust;
        logic [1:0]  status;
    } t_thrust_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_index;
    logic [23:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;

    thrust_curve_interpolator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Shadow copy of the curve table, updated as beats are accepted, and of the registers.
    logic [31:0]    shadow_times [tci_pkg::MAX_POINTS];
    logic [31:0]    shadow_thrusts [tci_pkg::MAX_POINTS];
    int unsigned    shadow_count;
    bit             shadow_loaded;
    logic [23:0]    shadow_ref_pressure;
    logic [23:0]    shadow_nozzle_area;

    t_curve_cmd     pending_cmds [$];
    t_thrust_result expected_thrusts [$];
    int             error_count;
    bit             quiet_tail;     // no idling on either side near the end
    bit             hold_sender;    // sender waits for the pipeline to drain
    int unsigned    sent_count;     // beats presented by the driver
    int unsigned    taken_count;    // beats accepted by the block

    function automatic logic [127:0] pack_cmd(t_curve_cmd c);
        return {6'd0, c.ambient_pressure, c.query_time, c.point_thrust,
                c.point_time, c.command};
    endfunction

    // Interpolated, pressure-corrected thrust for one command; updates the shadow table.
    function automatic t_thrust_result predict_thrust(t_curve_cmd c);
        t_thrust_result r;
        logic [31:0] t;
        longint f1, f2, d, base, dp, corr;
        longint unsigned mag, dq, dt, stp, pmag;
        int unsigned lo, hi, mid, i, n;
        r.thrust = '0;
        r.status = tci_pkg::ST_OK;
        if (c.command == tci_pkg::CMD_CLEAR) begin
            shadow_count = 0;
            shadow_loaded = 0;
        end else if (c.command == tci_pkg::CMD_APPEND) begin
            if (shadow_count >= tci_pkg::MAX_POINTS) begin
                r.status = tci_pkg::ST_FULL;
            end else begin
                t = c.point_time;
                if (shadow_count == 0) begin
                    if (t != 0) begin
                        shadow_times[0] = '0;
                        shadow_thrusts[0] = '0;
                        shadow_count = 1;
                    end
                end else if (t < shadow_times[shadow_count-1]) begin
                    t = shadow_times[shadow_count-1];
                end
                // The zero point only goes into an empty table, so a slot is always left here.
                if (shadow_count < tci_pkg::MAX_POINTS) begin
                    shadow_times[shadow_count] = t;
                    shadow_thrusts[shadow_count] = c.point_thrust;
                    shadow_count++;
                end
                shadow_loaded = 1;
            end
        end else if (c.command == tci_pkg::CMD_QUERY) begin
            n = shadow_count;
            if (!shadow_loaded || n < 2 || c.query_time > shadow_times[n-1]) begin
                r.status = tci_pkg::ST_RANGE;
            end else begin
                lo = 1;
                hi = n - 1;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_times[mid] < c.query_time) lo = mid + 1;
                    else hi = mid;
                end
                i = lo - 1;
                f1 = longint'(signed'(shadow_thrusts[i]));
                f2 = longint'(signed'(shadow_thrusts[i+1]));
                base = f1;
                if (shadow_times[i+1] > shadow_times[i] && c.query_time > shadow_times[i])
                begin
                    dt = shadow_times[i+1] - shadow_times[i];
                    dq = c.query_time - shadow_times[i];
                    if (dq > dt) dq = dt;
                    d = f2 - f1;
                    mag = (d < 0) ? -d : d;
                    stp = (mag * dq) / dt;
                    base = (d < 0) ? f1 - longint'(stp) : f1 + longint'(stp);
                end
                dp = longint'(shadow_ref_pressure) - longint'(c.ambient_pressure);
                pmag = (dp < 0) ? -dp : dp;
                pmag = (pmag * shadow_nozzle_area) >> 8;
                corr = (dp < 0) ? -longint'(pmag) : longint'(pmag);
                base += corr;
                if (base > 64'sd2147483647) base = 64'sd2147483647;
                if (base < -64'sd2147483648) base = -64'sd2147483648;
                r.thrust = base[31:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: presents queued beats, with random idle bursts unless in the quiet tail.
    int unsigned send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (sent_count != taken_count) begin
            // Beat still pending; hold it.
        end else if (send_gap > 0) begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0 && !hold_sender) begin
            s_axis_tdata <= pack_cmd(pending_cmds.pop_front());
            s_axis_tvalid <= 1'b1;
            sent_count++;
            if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 10);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Predict when the block takes a beat, so expectations keep acceptance order.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            taken_count++;
            expected_thrusts.push_back(predict_thrust(t_curve_cmd'({s_axis_tdata[1:0],
                s_axis_tdata[33:2], s_axis_tdata[65:34], s_axis_tdata[97:66],
                s_axis_tdata[121:98]} )));
        end
    end

    // Receiver stalls in random bursts.
    int unsigned stall_left;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_thrust_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_thrusts.size() == 0) begin
                report_mismatch("unexpected result beat", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = expected_thrusts.pop_front();
                if (m_axis_tdata[31:0] !== want.thrust)
                    report_mismatch("thrust", m_axis_tdata[31:0], want.thrust);
                if (m_axis_tdata[33:32] !== want.status)
                    report_mismatch("status", 32'(m_axis_tdata[33:32]), 32'(want.status));
            end
        end
    end

    function automatic t_curve_cmd make_cmd(logic [1:0] op, logic [31:0] pt, logic [31:0] pf,
                                            logic [31:0] qt, logic [23:0] amb);
        t_curve_cmd c;
        c.command = op;
        c.point_time = pt;
        c.point_thrust = pf;
        c.query_time = qt;
        c.ambient_pressure = amb;
        return c;
    endfunction

    function automatic logic [23:0] rand_pressure();
        case ($urandom_range(0, 3))
            0: return 24'd101325;
            1: return 24'hFFFFFF;
            2: return 24'd0;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // Waits until every queued beat has gone and every result has come back.
    task automatic drain();
        wait (pending_cmds.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid || expected_thrusts.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        shadow_ref_pressure = (idx == tci_pkg::REG_REF_PRESSURE) ? val : shadow_ref_pressure;
        shadow_nozzle_area = (idx == tci_pkg::REG_NOZZLE_AREA) ? val : shadow_nozzle_area;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A curve session: a clear, a mostly increasing sequence of points, then queries on it.
    task automatic queue_curve_session(int unsigned npts, int unsigned nq);
        logic [31:0] t, step_max;
        logic [31:0] last_t;
        t = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(1, 32'h0010_0000);
        last_t = t;
        step_max = ($urandom_range(0, 3) == 0) ? 32'h0100_0000 : 32'h0001_0000;
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_CLEAR, $urandom, $urandom, $urandom,
                                        24'($urandom)));
        for (int k = 0; k < npts; k++) begin
            case ($urandom_range(0, 9))
                0: ;                                        // repeated time
                1: t = t - $urandom_range(0, 1000);          // out of order
                default: t = t + $urandom_range(1, step_max);
            endcase
            pending_cmds.push_back(make_cmd(tci_pkg::CMD_APPEND, t, $urandom, $urandom,
                                            24'($urandom)));
            last_t = t;
        end
        for (int k = 0; k < nq; k++)
            pending_cmds.push_back(make_cmd(
                ($urandom_range(0, 19) == 0) ? tci_pkg::CMD_UNUSED : tci_pkg::CMD_QUERY,
                $urandom, $urandom,
                ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, last_t + 16),
                rand_pressure()));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_gap = 0;
        stall_left = 0;
        quiet_tail = 0;
        hold_sender = 0;
        sent_count = 0;
        taken_count = 0;
        error_count = 0;
        shadow_count = 0;
        shadow_loaded = 0;
        shadow_ref_pressure = 24'd101325;
        shadow_nozzle_area = 24'd0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty-table query, one point, zero-time insert, equal times,
        // out-of-order append, past-the-end query, extreme thrusts, unused command.
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_APPEND, 32'h0001_0000, 32'h7FFF_FFFF,
                                        0, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 32'h0000_8000, 24'd101325));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_APPEND, 32'h0001_0000, 32'h8000_0000,
                                        0, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 32'h0001_0000, 24'hFFFFFF));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_APPEND, 32'h0000_0001, 32'h0000_0100,
                                        0, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        0, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 24'd0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 32'h8000_0000, 24'd5));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 24'hFFFFFF));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_CLEAR, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_APPEND, 0, 32'h0000_1000, 0, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_APPEND, 32'h0000_0010, 32'hFFFF_F000,
                                        0, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 32'h0000_0011, 0));
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 32'h0000_0007, 0));
        drain();

        // Saturating pressure terms at both extremes of the registers.
        write_reg(tci_pkg::REG_NOZZLE_AREA, 24'hFFFFFF);
        write_reg(tci_pkg::REG_REF_PRESSURE, 24'hFFFFFF);
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 32'h0000_0001, 24'd0));
        drain();
        write_reg(tci_pkg::REG_REF_PRESSURE, 24'd0);
        pending_cmds.push_back(make_cmd(tci_pkg::CMD_QUERY, 0, 0, 32'h0000_0001, 24'hFFFFFF));
        drain();

        // Fill the table completely, then overflow it and query the full table.
        write_reg(tci_pkg::REG_REF_PRESSURE, 24'd101325);
        write_reg(tci_pkg::REG_NOZZLE_AREA, 24'h000100);
        queue_curve_session(tci_pkg::MAX_POINTS + 3, 20);
        // The sender stalls partway through until every result is back.
        wait (pending_cmds.size() < tci_pkg::MAX_POINTS);
        hold_sender = 1;
        @(posedge i_clk);
        while (s_axis_tvalid || expected_thrusts.size() > 0) @(posedge i_clk);
        hold_sender = 0;
        drain();

        // Random sessions across a few register settings.
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(tci_pkg::REG_REF_PRESSURE, rand_pressure());
            write_reg(tci_pkg::REG_NOZZLE_AREA,
                      (phase == 0) ? 24'd0 : 24'($urandom_range(0, 24'hFFFFFF)));
            for (int s = 0; s < 20; s++) begin
                queue_curve_session($urandom_range(0, 12), $urandom_range(5, 25));
                if (s == 5) begin
                    wait (pending_cmds.size() == 0);
                    hold_sender = 1;
                    while (expected_thrusts.size() > 0 || s_axis_tvalid) @(posedge i_clk);
                    hold_sender = 0;
                end
            end
            if (phase == 3) quiet_tail = 1;
            drain();
        end

        if (error_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
